// File: rtl/tass_pkg.sv
// Shared constants and helpers for the thermistor converter scan sequencer.
// Holds phase codes, result kind codes, register map and count clamps.
// No dependencies.
package tass_pkg;

    // Field widths of the item and result words.
    localparam int BYTE_W    = 8;
    localparam int ACTION_W  = 2;
    localparam int CHAN_W    = 4;
    localparam int CHIP_W    = 4;
    localparam int RAW_W     = 16;
    localparam int IN_DATA_W = 3 * BYTE_W;
    localparam int OUT_DATA_W = CHAN_W + CHIP_W + RAW_W;

    // Register widths.
    localparam int SETTLE_W    = 8;
    localparam int CHIPCNT_W   = 4;
    localparam int CHANCNT_W   = 5;
    localparam int ADDR_W      = 4;
    localparam int APB_DATA_W  = 32;

    // Register indexes (word addresses on the configuration port).
    localparam logic [1:0] REG_SETTLE_TICKS  = 2'd0;
    localparam logic [1:0] REG_CHIP_COUNT    = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    // Register reset values.
    localparam logic [SETTLE_W-1:0]  SETTLE_RESET  = 8'd200;
    localparam logic [CHIPCNT_W-1:0] CHIPCNT_RESET = 4'd10;
    localparam logic [CHANCNT_W-1:0] CHANCNT_RESET = 5'd16;

    // Scan limits.
    localparam logic [CHIPCNT_W-1:0] MAX_CHIPS    = 4'd10;
    localparam logic [CHANCNT_W-1:0] MAX_CHANNELS = 5'd16;

    // Phase codes; the fourth code behaves as the select phase.
    localparam logic [1:0] PH_SELECT = 2'd0;
    localparam logic [1:0] PH_WAIT   = 2'd1;
    localparam logic [1:0] PH_READ   = 2'd2;
    localparam logic [1:0] PH_SPARE  = 2'd3;

    // Result kinds carried on tuser.
    localparam logic [ACTION_W-1:0] ACT_WAIT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

    // Force a chip count into the range one to MAX_CHIPS.
    function automatic logic [CHIPCNT_W-1:0] clamp_chips(input logic [CHIPCNT_W-1:0] v);
        logic [CHIPCNT_W-1:0] r;
        if (v == '0) begin
            r = CHIPCNT_W'(1);
        end else if (v > MAX_CHIPS) begin
            r = MAX_CHIPS;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Force a channel count into the range one to MAX_CHANNELS.
    function automatic logic [CHANCNT_W-1:0] clamp_chans(input logic [CHANCNT_W-1:0] v);
        logic [CHANCNT_W-1:0] r;
        if (v == '0) begin
            r = CHANCNT_W'(1);
        end else if (v > MAX_CHANNELS) begin
            r = MAX_CHANNELS;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/thermistor_adc_scan_sequencer_unit.sv
// Top level of the thermistor converter scan sequencer: phase control, counters,
// result register and APB register file. Depends on tass_pkg.
//
// Every accepted word is one tick and yields exactly one result word. The block
// takes one word per clock: all sequencing is a small counter update done in the
// accepting cycle, and the result lands in a single output register. s_tready is
// high whenever that register is empty or is being drained in the same cycle, so
// a stalled result holds the input back only while it stays untaken. Results
// appear in the cycle after acceptance. Registers are written over APB at byte
// addresses 0 (settle_ticks), 4 (chip_count) and 8 (channel_count); they should
// be changed only while no tick is in flight.
module thermistor_adc_scan_sequencer_unit
    import tass_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // Tick words in.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // frame_byte_hi [7:0], frame_byte_mid [15:8], frame_byte_lo [23:16]
    input  logic [IN_DATA_W-1:0]    s_tdata,
    // Result words out.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // channel_index [3:0], chip_index [7:4], raw_count [23:8]
    output logic [OUT_DATA_W-1:0]   m_tdata,
    // action [1:0]
    output logic [ACTION_W-1:0]     m_tuser,
    // Configuration port.
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    // Configuration registers.
    logic [SETTLE_W-1:0]  settle_ticks_reg;
    logic [CHIPCNT_W-1:0] chip_count_reg;
    logic [CHANCNT_W-1:0] channel_count_reg;

    // Sequencer state.
    logic [1:0]            phase_reg, phase_next;
    logic [CHANCNT_W-1:0]  chan_ptr_reg, chan_ptr_next;
    logic [CHIP_W-1:0]     chip_ptr_reg, chip_ptr_next;
    logic [SETTLE_W-1:0]   settle_cnt_reg, settle_cnt_next;

    // Result register.
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [ACTION_W-1:0]   out_user_reg, out_user_next;

    logic                  s_acc;
    logic                  cfg_wr;
    logic [1:0]            reg_idx;

    // Working signals of the step logic.
    logic [SETTLE_W-1:0]   settle_limit;
    logic [SETTLE_W:0]     settle_inc;
    logic [CHIPCNT_W-1:0]  chips_eff;
    logic [CHIPCNT_W:0]    chip_inc;
    logic [CHANCNT_W-1:0]  chans_eff;
    logic [CHANCNT_W-1:0]  chan_sel;
    logic [CHAN_W-1:0]     chan_out;
    logic [CHIP_W-1:0]     chip_out;
    logic [RAW_W-1:0]      raw_out;
    logic [BYTE_W-1:0]     byte_hi, byte_mid, byte_lo;

    assign byte_hi  = s_tdata[BYTE_W-1:0];
    assign byte_mid = s_tdata[2*BYTE_W-1:BYTE_W];
    assign byte_lo  = s_tdata[3*BYTE_W-1:2*BYTE_W];

    // Handshakes.
    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // APB: always ready, registers decoded on word address.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (reg_idx)
            REG_SETTLE_TICKS:  prdata = APB_DATA_W'(settle_ticks_reg);
            REG_CHIP_COUNT:    prdata = APB_DATA_W'(chip_count_reg);
            REG_CHANNEL_COUNT: prdata = APB_DATA_W'(channel_count_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_ticks_reg  <= SETTLE_RESET;
            chip_count_reg    <= CHIPCNT_RESET;
            channel_count_reg <= CHANCNT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SETTLE_TICKS:  settle_ticks_reg  <= pwdata[SETTLE_W-1:0];
                REG_CHIP_COUNT:    chip_count_reg    <= pwdata[CHIPCNT_W-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[CHANCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective limits and shared increments.
    assign settle_limit = (settle_ticks_reg == '0) ? SETTLE_W'(1) : settle_ticks_reg;
    assign settle_inc   = {1'b0, settle_cnt_reg} + (SETTLE_W+1)'(1);
    assign chips_eff    = clamp_chips(chip_count_reg);
    assign chip_inc     = {1'b0, chip_ptr_reg} + (CHIPCNT_W+1)'(1);
    assign chans_eff    = clamp_chans(channel_count_reg);
    assign chan_sel     = (chan_ptr_reg >= chans_eff) ? '0 : chan_ptr_reg;

    // One tick: next state and the result word.
    always_comb begin
        phase_next      = phase_reg;
        chan_ptr_next   = chan_ptr_reg;
        chip_ptr_next   = chip_ptr_reg;
        settle_cnt_next = settle_cnt_reg;
        out_user_next   = ACT_WAIT;
        chan_out        = '0;
        chip_out        = '0;
        raw_out         = '0;
        unique case (phase_reg)
            PH_WAIT: begin
                if (settle_inc >= {1'b0, settle_limit}) begin
                    settle_cnt_next = '0;
                    phase_next      = PH_READ;
                end else begin
                    settle_cnt_next = settle_inc[SETTLE_W-1:0];
                end
            end
            PH_READ: begin
                out_user_next = ACT_SAMPLE;
                raw_out  = {byte_hi[5:0], byte_mid, byte_lo[7:6]};
                chan_out = chan_ptr_reg[CHAN_W-1:0] - CHAN_W'(1);
                chip_out = chip_ptr_reg;
                if (chip_inc >= {1'b0, chips_eff}) begin
                    chip_ptr_next = '0;
                    phase_next    = PH_SELECT;
                end else begin
                    chip_ptr_next = chip_inc[CHIP_W-1:0];
                end
            end
            // The spare code acts as the select phase.
            PH_SELECT, PH_SPARE: begin
                out_user_next = ACT_SELECT;
                chan_out      = chan_sel[CHAN_W-1:0];
                chan_ptr_next = chan_sel + CHANCNT_W'(1);
                phase_next    = PH_WAIT;
            end
            default: ;
        endcase
        out_data_next = {raw_out, chip_out, chan_out};
    end

    // State advances once per accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SELECT;
            chan_ptr_reg   <= '0;
            chip_ptr_reg   <= '0;
            settle_cnt_reg <= '0;
        end else if (s_acc) begin
            phase_reg      <= phase_next;
            chan_ptr_reg   <= chan_ptr_next;
            chip_ptr_reg   <= chip_ptr_next;
            settle_cnt_reg <= settle_cnt_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_acc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

`ifndef SYNTHESIS
    // A tick taken in the select phase yields a select command next cycle.
    a_select_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && phase_reg == PH_SELECT) |=> (m_tvalid && m_tuser == ACT_SELECT))
        else $error("select tick did not produce a channel select word");

    // A read either steps the chip pointer or ends the chip sweep.
    a_chip_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && phase_reg == PH_READ) |=>
            ((phase_reg == PH_SELECT && chip_ptr_reg == '0) ||
             (phase_reg == PH_READ && chip_ptr_reg == CHIP_W'($past(chip_ptr_reg) + 4'd1))))
        else $error("chip pointer did not advance correctly after a read");

    // Pointers stay within the scan limits.
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (chip_ptr_reg < MAX_CHIPS) && (chan_ptr_reg <= MAX_CHANNELS))
        else $error("scan pointer out of range");

    // The settle counter is cleared outside the wait phase.
    a_settle_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_WAIT) |-> (settle_cnt_reg == '0))
        else $error("settle counter not cleared outside the wait phase");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for thermistor_adc_scan_sequencer_unit. It sends tick words
// and APB register writes, predicts each result word and compares it with the DUT.
// Depends on tass_pkg and the RTL top level.
module testbench
    import tass_pkg::*;
();

    // One result word split into its fields.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAN_W-1:0]   channel;
        logic [CHIP_W-1:0]   chip;
        logic [RAW_W-1:0]    raw;
    } scan_result_t;

    // DUT ports, all inputs known from time zero.
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [ACTION_W-1:0]   m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow registers and scan state of the predictor.
    logic [SETTLE_W-1:0]   cfg_settle  = SETTLE_RESET;
    logic [CHIPCNT_W-1:0]  cfg_chips   = CHIPCNT_RESET;
    logic [CHANCNT_W-1:0]  cfg_chans   = CHANCNT_RESET;
    logic [1:0]            scan_phase  = PH_SELECT;
    logic [CHANCNT_W-1:0]  chan_ptr    = '0;
    logic [CHIPCNT_W-1:0]  chip_ptr    = '0;
    logic [SETTLE_W-1:0]   settle_cnt  = '0;

    // Results predicted but not yet seen on the master side.
    scan_result_t awaited_scan_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned errors        = 0;
    int unsigned ticks_sent    = 0;
    int unsigned selects_seen  = 0;
    int unsigned waits_seen    = 0;
    int unsigned samples_seen  = 0;

    always #5 aclk = ~aclk;

    thermistor_adc_scan_sequencer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Advance the scan by one tick and return the word it should produce.
    function automatic scan_result_t advance_scan(input logic [IN_DATA_W-1:0] frame);
        scan_result_t r;
        int unsigned settle_lim;
        int unsigned chip_lim;
        int unsigned chan_lim;
        logic [31:0] packed_count;
        r = '0;
        case (scan_phase)
            PH_WAIT: begin
                settle_lim = (cfg_settle == 0) ? 1 : cfg_settle;
                r.action = ACT_WAIT;
                if (int'(settle_cnt) + 1 >= settle_lim) begin
                    settle_cnt = '0;
                    scan_phase = PH_READ;
                end else begin
                    settle_cnt = settle_cnt + 1'b1;
                end
            end
            PH_READ: begin
                chip_lim = (cfg_chips == 0) ? 1 : (cfg_chips > MAX_CHIPS ? MAX_CHIPS : cfg_chips);
                packed_count = (32'(frame[7:0]) << 10) | (32'(frame[15:8]) << 2)
                             | (32'(frame[23:16]) >> 6);
                r.action  = ACT_SAMPLE;
                r.raw     = packed_count[RAW_W-1:0];
                r.channel = CHAN_W'(chan_ptr - 1'b1);
                r.chip    = chip_ptr;
                if (int'(chip_ptr) + 1 >= chip_lim) begin
                    chip_ptr   = '0;
                    scan_phase = PH_SELECT;
                end else begin
                    chip_ptr = chip_ptr + 1'b1;
                end
            end
            default: begin
                // The spare phase code falls in here as a select.
                chan_lim = (cfg_chans == 0) ? 1
                         : (cfg_chans > MAX_CHANNELS ? MAX_CHANNELS : cfg_chans);
                if (chan_ptr >= chan_lim) begin
                    chan_ptr = '0;
                end
                r.action   = ACT_SELECT;
                r.channel  = chan_ptr[CHAN_W-1:0];
                chan_ptr   = chan_ptr + 1'b1;
                scan_phase = PH_WAIT;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Send one tick word, with random idle cycles ahead of it.
    task automatic send_tick(input logic [IN_DATA_W-1:0] frame);
        @(negedge aclk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = frame;
        do @(posedge aclk); while (!s_tready);
        awaited_scan_results.push_back(advance_scan(frame));
        ticks_sent++;
    endtask

    task automatic run_ticks(input int unsigned count);
        repeat (count) send_tick(IN_DATA_W'($urandom()));
    endtask

    // Write one register once the scan is drained, then read it back.
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] stored;
        logic [APB_DATA_W-1:0] readback;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (awaited_scan_results.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_SETTLE_TICKS: begin
                cfg_settle = value[SETTLE_W-1:0];
                stored     = APB_DATA_W'(cfg_settle);
            end
            REG_CHIP_COUNT: begin
                cfg_chips = value[CHIPCNT_W-1:0];
                stored    = APB_DATA_W'(cfg_chips);
            end
            default: begin
                cfg_chans = value[CHANCNT_W-1:0];
                stored    = APB_DATA_W'(cfg_chans);
            end
        endcase
        // Read transfer straight after the write.
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        check_field("register readback", stored, readback);
    endtask

    task automatic set_scan(input int unsigned settle, input int unsigned chips,
                            input int unsigned chans);
        write_reg(REG_SETTLE_TICKS, settle);
        write_reg(REG_CHIP_COUNT, chips);
        write_reg(REG_CHANNEL_COUNT, chans);
    endtask

    // Receiver pacing: drop m_tready at random.
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Compare every accepted result word with the oldest prediction.
    always @(posedge aclk) begin
        scan_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_scan_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual tuser=%0d tdata=%h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = awaited_scan_results.pop_front();
                check_field("action", want.action, m_tuser);
                check_field("channel_index", want.channel, m_tdata[CHAN_W-1:0]);
                check_field("chip_index", want.chip, m_tdata[CHAN_W+CHIP_W-1:CHAN_W]);
                check_field("raw_count", want.raw, m_tdata[OUT_DATA_W-1:CHAN_W+CHIP_W]);
                case (want.action)
                    ACT_SELECT: selects_seen++;
                    ACT_SAMPLE: samples_seen++;
                    default:    waits_seen++;
                endcase
            end
        end
    end

    // Reset register values: one full settle of 200 and a read of all ten chips.
    task automatic test_reset_scan();
        run_ticks(214);
    endtask

    // Frame extremes, each placed on a read tick.
    task automatic test_frame_extremes();
        logic [IN_DATA_W-1:0] frames[14];
        frames = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hC00000,
                   24'h3F0000, 24'h400000, 24'h800000, 24'hAA55AA, 24'h55AA55,
                   24'h800001, 24'h7F0180, 24'hFF00FF, 24'h00FFFF};
        set_scan(1, 10, 16);
        foreach (frames[i]) begin
            while (scan_phase != PH_READ) run_ticks(1);
            send_tick(frames[i]);
        end
    endtask

    // Zero and oversized counts, and a channel count above sixteen to force the wrap.
    task automatic test_count_clamps();
        set_scan(0, 0, 0);
        run_ticks(8);
        set_scan(1, 15, 31);
        run_ticks(26);
        set_scan(1, 1, 31);
        run_ticks(52);
        set_scan(2, 11, 17);
        run_ticks(14);
    endtask

    // Longest settle time.
    task automatic test_long_settle();
        set_scan(255, 2, 3);
        run_ticks(262);
    endtask

    // Random settings changed between bursts, so scans are cut short mid-way.
    task automatic test_random_scans(input int unsigned rounds);
        repeat (rounds) begin
            set_scan($urandom_range(6, 0), $urandom_range(15, 0), $urandom_range(31, 0));
            run_ticks($urandom_range(25, 10));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 48;
        test_reset_scan();
        test_frame_extremes();
        test_count_clamps();

        send_idle_pct = 48;
        recv_idle_pct = 17;
        test_long_settle();
        test_random_scans(3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_scans(3);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (awaited_scan_results.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("Scanned %0d ticks: %0d channel selects, %0d settle ticks, %0d samples,",
                 ticks_sent, selects_seen, waits_seen, samples_seen);
        $display("with clamped, extreme and random register settings and three pacing modes.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
